FILE: rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants for the linked free-list identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

    localparam int ID_W      = 10;
    localparam int LINK_DEPTH = 1 << ID_W;

    localparam logic [ID_W-1:0] MAX_IDS   = ID_W'(1023);
    localparam logic [ID_W-1:0] POOL_INIT = ID_W'(1023);
    localparam logic [ID_W-1:0] NULL_ID   = '0;
    localparam logic [ID_W-1:0] FIRST_ID  = ID_W'(1);
    localparam logic [ID_W-1:0] LAST_IDX  = ID_W'(LINK_DEPTH - 1);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef struct packed {
        logic            in_use;
        logic [ID_W-1:0] link;
    } link_entry_t;

    typedef struct packed {
        logic            re;
        logic [ID_W-1:0] raddr;
        logic            we;
        logic [ID_W-1:0] waddr;
        link_entry_t     wdata;
    } ram_req_t;

endpackage

`default_nettype wire

FILE: rtl/fla_link_ram.sv
// ----------------------------------------------------------------------------
// fla_link_ram
// Link memory: one entry per identifier holding its in-use mark and the
// next identifier on the free list. One write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_link_ram
    import fla_pkg::*;
(
    input  wire logic        clk,
    input  var  ram_req_t    ram_req,
    output link_entry_t      rdata
);

    link_entry_t mem [LINK_DEPTH];
    link_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re)
        begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl
// Sequencer for the allocator: holds the head pointer and pool size, runs
// the initialization sweep, and performs the read-modify-write of each
// request against the link memory.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ctrl
    import fla_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire logic            command,
    input  wire logic [ID_W-1:0] release_id,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output logic [ID_W-1:0]      granted_id,
    output logic [1:0]           status,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [ID_W-1:0] pool_size,
    output ram_req_t             ram_req,
    input  var  link_entry_t     rdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t          state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] head_reg, head_next;
    logic [ID_W-1:0] pool_reg, pool_next;
    logic            clearing_reg, clearing_next;
    logic [ID_W-1:0] clr_idx_reg, clr_idx_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0] granted_reg, granted_next;
    status_t         status_reg, status_next;

    logic [ID_W-1:0] eff_size;
    logic            accept;
    logic            out_free;
    logic            cfg_write;

    assign eff_size  = (pool_reg > MAX_IDS) ? MAX_IDS : pool_reg;
    assign req_stall = (state_reg != S_IDLE) || clearing_reg;
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        pool_next      = pool_reg;
        clearing_next  = clearing_reg;
        clr_idx_next   = clr_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        granted_next   = granted_reg;
        status_next    = status_reg;
        ram_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (clearing_reg)
                begin
                    ram_req.we          = 1'b1;
                    ram_req.waddr       = clr_idx_reg;
                    ram_req.wdata.in_use = 1'b0;
                    ram_req.wdata.link  = ((clr_idx_reg != NULL_ID) && (clr_idx_reg < eff_size))
                                          ? ID_W'(clr_idx_reg + FIRST_ID) : NULL_ID;
                    clr_idx_next = ID_W'(clr_idx_reg + FIRST_ID);
                    if (clr_idx_reg == LAST_IDX)
                    begin
                        clearing_next = 1'b0;
                    end
                end
                else if (accept)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = (command == CMD_ALLOC) ? head_reg : release_id;
                    cmd_next      = command;
                    id_next       = release_id;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    granted_next   = NULL_ID;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if ((head_reg == NULL_ID) || (head_reg > eff_size))
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            granted_next         = head_reg;
                            head_next            = rdata.link;
                            ram_req.we           = 1'b1;
                            ram_req.waddr        = head_reg;
                            ram_req.wdata.in_use = 1'b1;
                            ram_req.wdata.link   = NULL_ID;
                        end
                    end
                    else
                    begin
                        if ((id_reg == NULL_ID) || (id_reg > eff_size) || !rdata.in_use)
                        begin
                            status_next = ST_BAD_FREE;
                        end
                        else
                        begin
                            head_next            = id_reg;
                            ram_req.we           = 1'b1;
                            ram_req.waddr        = id_reg;
                            ram_req.wdata.in_use = 1'b0;
                            ram_req.wdata.link   = head_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            pool_next     = pool_size;
            clearing_next = 1'b1;
            clr_idx_next  = NULL_ID;
            head_next     = (pool_size != NULL_ID) ? FIRST_ID : NULL_ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_ALLOC;
            id_reg        <= NULL_ID;
            head_reg      <= FIRST_ID;
            pool_reg      <= POOL_INIT;
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= NULL_ID;
            rsp_valid_reg <= 1'b0;
            granted_reg   <= NULL_ID;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            id_reg        <= id_next;
            head_reg      <= head_next;
            pool_reg      <= pool_next;
            clearing_reg  <= clearing_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            granted_reg   <= granted_next;
            status_reg    <= status_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

FILE: rtl/free_list_id_allocator.sv
// ----------------------------------------------------------------------------
// free_list_id_allocator
// Hands out and takes back identifiers from a free list kept as a head
// pointer plus a link memory.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  command, release_id
//   rsp      out        rsp_valid / rsp_stall  granted_id, status
//   cfg      in         cfg_valid / cfg_ready  pool_size
//
// Each request reads its link memory entry in S_IDLE and writes it back in
// S_EXEC, so no new request is accepted until the previous one is finished.
// After reset, and after every pool_size write, a sweep over all 1024 entries
// rebuilds the list and no request is accepted until it finishes.
// A stalled response is held in its register; the next request may still be
// accepted, but its write-back waits until the response slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_id_allocator
    import fla_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire logic            command,
    input  wire logic [ID_W-1:0] release_id,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output logic [ID_W-1:0]      granted_id,
    output logic [1:0]           status,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [ID_W-1:0] pool_size
);

    ram_req_t    ram_req;
    link_entry_t rdata;

    fla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .release_id (release_id),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .granted_id (granted_id),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .pool_size  (pool_size),
        .ram_req    (ram_req),
        .rdata      (rdata)
    );

    fla_link_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

endmodule

`default_nettype wire
